### rtl/i2cm_pkg.sv
// Shared types, codes and constants of the I2C master byte engine.
package i2cm_pkg;

    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_STOP  = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;
    localparam logic [1:0] OP_READ  = 2'd3;

    localparam int unsigned CMD_QUEUE_DEPTH = 2;
    localparam logic [15:0] HALF_PERIOD_RESET = 16'd250;

    localparam logic [4:0] LAST_PHASE_COND = 5'd2;
    localparam logic [4:0] LAST_PHASE_BYTE = 5'd17;
    localparam logic [3:0] ACK_CLOCK       = 4'd8;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] tx_byte;
        logic       master_nack;
        logic [7:0] slave_byte;
        logic       slave_ack;
    } in_item_t;

    typedef struct packed {
        logic       scl;
        logic       sda_pull_low;
        logic [7:0] rx_byte;
        logic       ack_seen;
        logic       last;
    } out_item_t;

    // Classified command: data is tx_byte for a write and slave_byte for a read;
    // flag is slave_ack for a write and master_nack for a read.
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic       flag;
    } cmd_t;

endpackage

### rtl/i2cm_front.sv
// Command front end: accepts items, classifies them and queues them for the bus sequencer.
module i2cm_front #(
    parameter int unsigned QueueDepth = i2cm_pkg::CMD_QUEUE_DEPTH
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    output logic               cmd_ready,
    input  i2cm_pkg::in_item_t cmd,
    output logic               q_valid,
    input  logic               q_pop,
    output i2cm_pkg::cmd_t     q_head
);

    localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
    localparam int unsigned CntW = $clog2(QueueDepth + 1);
    localparam logic [PtrW-1:0] LastPtr = PtrW'(QueueDepth - 1);
    localparam logic [CntW-1:0] FullCnt = CntW'(QueueDepth);

    i2cm_pkg::cmd_t slot_reg [QueueDepth];
    logic [PtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0] count_reg, count_next;
    i2cm_pkg::cmd_t  decoded;
    logic            push;

    // Keep only the fields that matter for each kind of command.
    always_comb
    begin
        decoded.kind = cmd.op;
        case (cmd.op)
            i2cm_pkg::OP_WRITE:
            begin
                decoded.data = cmd.tx_byte;
                decoded.flag = cmd.slave_ack;
            end
            i2cm_pkg::OP_READ:
            begin
                decoded.data = cmd.slave_byte;
                decoded.flag = cmd.master_nack;
            end
            default:
            begin
                decoded.data = 8'd0;
                decoded.flag = 1'b0;
            end
        endcase
    end

    assign cmd_ready = (count_reg != FullCnt);
    assign push      = cmd_valid && cmd_ready;
    assign q_valid   = (count_reg != '0);
    assign q_head    = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LastPtr) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (q_pop && q_valid)
        begin
            rd_ptr_next = (rd_ptr_reg == LastPtr) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !(q_pop && q_valid))
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && q_pop && q_valid)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= decoded;
        end
    end

endmodule

### rtl/i2cm_back.sv
// Bus sequencer: turns one queued command into its run of SCL half periods.
module i2cm_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [15:0]         half_period,
    input  logic                q_valid,
    output logic                q_pop,
    input  i2cm_pkg::cmd_t      q_head,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output i2cm_pkg::out_item_t rsp
);

    logic                busy_reg, busy_next;
    i2cm_pkg::cmd_t      cmd_reg, cmd_next;
    logic [4:0]          phase_reg, phase_next;
    logic [15:0]         wait_reg, wait_next;
    logic                out_valid_reg, out_valid_next;
    i2cm_pkg::out_item_t out_reg, out_next;

    i2cm_pkg::out_item_t item;
    logic [3:0]          clk_idx;
    logic [2:0]          bit_sel;
    logic                is_last;
    logic                emit;

    assign clk_idx = phase_reg[4:1];
    assign bit_sel = 3'd7 - clk_idx[2:0];

    // Build the half period for the current phase.
    always_comb
    begin
        item = '0;
        item.scl = phase_reg[0];
        case (cmd_reg.kind)
            i2cm_pkg::OP_START:
            begin
                item.scl          = (phase_reg != i2cm_pkg::LAST_PHASE_COND);
                item.sda_pull_low = (phase_reg != 5'd0);
                item.last         = (phase_reg == i2cm_pkg::LAST_PHASE_COND);
            end
            i2cm_pkg::OP_STOP:
            begin
                item.scl          = (phase_reg != 5'd0);
                item.sda_pull_low = (phase_reg != i2cm_pkg::LAST_PHASE_COND);
                item.last         = (phase_reg == i2cm_pkg::LAST_PHASE_COND);
            end
            i2cm_pkg::OP_WRITE:
            begin
                // Release SDA on the ack clock and report what the slave drove.
                item.sda_pull_low = (clk_idx != i2cm_pkg::ACK_CLOCK) && !cmd_reg.data[bit_sel];
                item.last         = (phase_reg == i2cm_pkg::LAST_PHASE_BYTE);
                item.ack_seen     = item.last && cmd_reg.flag;
            end
            i2cm_pkg::OP_READ:
            begin
                item.sda_pull_low = (clk_idx == i2cm_pkg::ACK_CLOCK) && !cmd_reg.flag;
                item.last         = (phase_reg == i2cm_pkg::LAST_PHASE_BYTE);
                item.rx_byte      = item.last ? cmd_reg.data : 8'd0;
            end
            default:
            begin
                item = '0;
            end
        endcase
    end

    assign is_last = item.last;
    assign emit    = busy_reg && (wait_reg == '0) && (!out_valid_reg || rsp_ready);
    assign q_pop   = !busy_reg && q_valid;

    always_comb
    begin
        busy_next      = busy_reg;
        cmd_next       = cmd_reg;
        phase_next     = phase_reg;
        wait_next      = wait_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;

        if (out_valid_reg && rsp_ready)
        begin
            out_valid_next = 1'b0;
        end

        // Let the last half period of a run run out before the next run starts.
        if (wait_reg != '0)
        begin
            wait_next = wait_reg - 1'b1;
        end

        if (q_pop)
        begin
            busy_next  = 1'b1;
            cmd_next   = q_head;
            phase_next = '0;
        end
        else if (emit)
        begin
            out_valid_next = 1'b1;
            out_next       = item;
            // Hold each half period for the programmed count; zero acts as one.
            wait_next      = (half_period == '0) ? '0 : half_period - 1'b1;
            phase_next     = phase_reg + 1'b1;
            if (is_last)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            phase_reg     <= '0;
            wait_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            phase_reg     <= phase_next;
            wait_reg      <= wait_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        out_reg <= out_next;
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

endmodule

### rtl/i2c_master_byte_engine.sv
// Top level of the I2C master byte engine: divider register, command queue and bus sequencer.
// Each command (start, stop, write byte, read byte) becomes a run of SCL half-period items:
// three for start and stop, eighteen for a byte. Items leave one per half period while the output is
// not stalled by rsp_ready; the half-period length comes from the divider register (a value of 0
// counts as 1), and the half-period counter in the sequencer sets the rate. A small command queue
// accepts commands, until it is full, while the sequencer works and while a finished item waits
// at the output. The last item of each run carries the received byte (read) or the ack seen
// (write). Write the divider only while the engine is idle.
module i2c_master_byte_engine #(
    parameter int unsigned QueueDepth = i2cm_pkg::CMD_QUEUE_DEPTH
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [15:0]         cfg_data,
    input  logic                cmd_valid,
    output logic                cmd_ready,
    input  i2cm_pkg::in_item_t  cmd,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output i2cm_pkg::out_item_t rsp
);

    logic [15:0]    half_period_reg, half_period_next;
    logic           q_valid;
    logic           q_pop;
    i2cm_pkg::cmd_t q_head;

    assign cfg_ready        = 1'b1;
    assign half_period_next = (cfg_valid && cfg_ready) ? cfg_data : half_period_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_period_reg <= i2cm_pkg::HALF_PERIOD_RESET;
        end
        else
        begin
            half_period_reg <= half_period_next;
        end
    end

    i2cm_front #(
        .QueueDepth (QueueDepth)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_head    (q_head)
    );

    i2cm_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .half_period (half_period_reg),
        .q_valid     (q_valid),
        .q_pop       (q_pop),
        .q_head      (q_head),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp_ready),
        .rsp         (rsp)
    );

endmodule
